// ===== hw/rtl/dss_pkg.sv =====
// Shared types and constants of the delimiter string splitter.
package dss_pkg;

  localparam int MAX_DELIM_LEN = 8;

  // Configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 64;

  localparam logic [CFG_AW-1:0] CFG_IDX_DELIM_LEN   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_IDX_DELIM_BYTES = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_IDX_KEEP_EMPTY  = 2'd2;

  localparam logic [3:0]  DELIM_LEN_RST   = 4'd1;
  localparam logic [63:0] DELIM_BYTES_RST = 64'd44;
  localparam logic        KEEP_EMPTY_RST  = 1'b0;

  // Delimiter bytes beyond the register read as zero, up to the largest window.
  localparam int DELIM_PAD_W = 128;

  // Result kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [3:0]  delim_len;
    logic [63:0] delim_bytes;
    logic        keep_empty;
  } cfg_t;

  typedef struct packed {
    logic [7:0] dbyte;
    logic       kind;
    logic       done;
  } res_t;

  localparam res_t RES_NONE = '{dbyte: 8'h00, kind: KIND_BYTE, done: 1'b0};

endpackage

// ===== hw/rtl/dss_cfg.sv =====
// Configuration registers of the delimiter string splitter.
module dss_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [dss_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [dss_pkg::CFG_DW-1:0] cfg_wdata,
  output dss_pkg::cfg_t              cfg
);
  import dss_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delim_len   <= DELIM_LEN_RST;
      cfg_r.delim_bytes <= DELIM_BYTES_RST;
      cfg_r.keep_empty  <= KEEP_EMPTY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IDX_DELIM_LEN:   cfg_r.delim_len   <= cfg_wdata[3:0];
        CFG_IDX_DELIM_BYTES: cfg_r.delim_bytes <= cfg_wdata[63:0];
        CFG_IDX_KEEP_EMPTY:  cfg_r.keep_empty  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/dss_core.sv =====
// Input register, held window and the single-pass split logic.
module dss_core #(
  parameter int P = dss_pkg::MAX_DELIM_LEN
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,
  input  logic                         in_tuser,
  input  logic                         in_tlast,
  input  dss_pkg::cfg_t                cfg,
  input  logic                         emit_free,
  output logic                         bnd_load,
  output dss_pkg::res_t [P:0]          bnd_ent,
  output logic [$clog2(P+2)-1:0]       bnd_cnt
);
  import dss_pkg::*;

  localparam int CW = $clog2(P + 1);
  localparam int BW = $clog2(P + 2);
  localparam int WW = 8 * P;

  // Input register
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] data_r;
  logic       has_r;
  logic       last_r;

  // Held window, oldest byte in the low bits
  logic [WW-1:0] win_r, win_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          tne_r, tne_nxt;

  logic                   go;
  logic [4:0]             len_w;
  logic [CW-1:0]          cnt_app;
  logic [WW-1:0]          win_app;
  logic [P-1:0]           eq;
  logic [P-1:0]           lmask;
  logic [DELIM_PAD_W-1:0] dpad;
  logic                   match;
  logic                   step;
  logic                   first_v;
  res_t                   first_res;
  logic [WW-1:0]          win_post;
  logic [CW-1:0]          cnt_post;
  logic                   tne_post;
  logic [WW+7:0]          win_pad;
  logic                   end_v;

  assign go        = in_valid_r & emit_free;
  assign in_tready = ~in_valid_r | go;
  assign bnd_load  = go;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (go) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
      has_r  <= in_tuser;
      last_r <= in_tlast;
    end
  end

  // Effective delimiter length: zero acts as one, clipped to the window size.
  always_comb begin
    len_w = {1'b0, cfg.delim_len};
    if (len_w == 5'd0) begin
      len_w = 5'd1;
    end else if (len_w > 5'(P)) begin
      len_w = 5'(P);
    end
  end

  assign dpad    = {{(DELIM_PAD_W-64){1'b0}}, cfg.delim_bytes};
  assign cnt_app = cnt_r + CW'(has_r);

  always_comb begin
    for (int j = 0; j < P; j++) begin
      if (has_r && (j == int'(cnt_r))) begin
        win_app[8*j +: 8] = data_r;
      end else begin
        win_app[8*j +: 8] = win_r[8*j +: 8];
      end
      eq[j]    = (win_app[8*j +: 8] == dpad[8*j +: 8]);
      lmask[j] = (5'(j) < len_w);
    end
  end

  assign match = &(eq | ~lmask);
  assign step  = has_r & (5'(cnt_app) >= len_w);

  always_comb begin
    first_v   = 1'b0;
    first_res = RES_NONE;
    win_post  = win_app;
    cnt_post  = cnt_app;
    tne_post  = tne_r;
    if (step) begin
      if (match) begin
        first_v        = cfg.keep_empty | tne_r;
        first_res.kind = KIND_END;
        win_post       = win_app >> {len_w, 3'b000};
        cnt_post       = CW'(5'(cnt_app) - len_w);
        tne_post       = 1'b0;
      end else begin
        first_v         = 1'b1;
        first_res.dbyte = win_app[7:0];
        win_post        = win_app >> 8;
        cnt_post        = cnt_app - CW'(1);
        tne_post        = 1'b1;
      end
    end
  end

  assign win_pad = {8'h00, win_post};
  assign end_v   = cfg.keep_empty | tne_post | (cnt_post != '0);

  // Result list: the step result, then on the last item the flushed bytes and,
  // unless the last token is empty and empty tokens are dropped, the token end.
  always_comb begin
    int idx;
    for (int k = 0; k <= P; k++) begin
      idx        = k - int'(first_v);
      bnd_ent[k] = RES_NONE;
      if (first_v && k == 0) begin
        bnd_ent[k] = first_res;
      end else if (last_r && idx < int'(cnt_post)) begin
        bnd_ent[k].dbyte = first_v ? win_pad[8*((k > 0) ? k - 1 : 0) +: 8]
                                   : win_pad[8*k +: 8];
      end else if (last_r && end_v && idx == int'(cnt_post)) begin
        bnd_ent[k].kind = KIND_END;
        bnd_ent[k].done = 1'b1;
      end
    end
  end

  always_comb begin
    if (last_r) begin
      bnd_cnt = BW'(first_v) + BW'(cnt_post) + BW'(end_v);
    end else begin
      bnd_cnt = BW'(first_v);
    end
  end

  always_comb begin
    win_nxt = win_post;
    cnt_nxt = last_r ? '0 : cnt_post;
    tne_nxt = last_r ? 1'b0 : tne_post;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      tne_r <= 1'b0;
    end else if (go) begin
      cnt_r <= cnt_nxt;
      tne_r <= tne_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      win_r <= win_nxt;
    end
  end

endmodule

// ===== hw/rtl/dss_emit.sv =====
// Result register: shifts one item's results out, one transaction a cycle while out_tready is high.
module dss_emit #(
  parameter int P = dss_pkg::MAX_DELIM_LEN
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   bnd_load,
  input  dss_pkg::res_t [P:0]    bnd_ent,
  input  logic [$clog2(P+2)-1:0] bnd_cnt,
  output logic                   emit_free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);
  import dss_pkg::*;

  localparam int BW = $clog2(P + 2);

  res_t [P:0]    ent_r, ent_nxt;
  logic [BW-1:0] cnt_r, cnt_nxt;
  logic          take;

  assign out_tvalid = (cnt_r != '0);
  assign take       = out_tvalid & out_tready;
  assign emit_free  = (cnt_r == '0) | (take & (cnt_r == BW'(1)));

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (bnd_load) begin
      ent_nxt = bnd_ent;
      cnt_nxt = bnd_cnt;
    end else if (take) begin
      for (int k = 0; k < P; k++) begin
        ent_nxt[k] = ent_r[k+1];
      end
      ent_nxt[P] = RES_NONE;
      cnt_nxt    = cnt_r - BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign out_tdata = ent_r[0].dbyte;
  assign out_tuser = {ent_r[0].done, ent_r[0].kind};
  assign out_tlast = (cnt_r == BW'(1));

endmodule

// ===== hw/rtl/delimiter_string_splitter_unit.sv =====
// Top level of the delimiter string splitter.
//
//  Channel  Direction  Payload                                   Handshake
//  in_      slave      tdata=data_byte tuser=has_byte tlast=last tvalid/tready
//  out_     master     tdata=out_byte tuser={string_done,kind}   tvalid/tready
//                      tlast=run_last
//  cfg_     write      addr=register index, wdata=value          cfg_we
//
// An accepted byte passes the input register into the result register. Bytes
// that give at most one result stream at one transaction per cycle unless the
// output stalls; an item that gives more holds the result register and input
// until its last result is taken. Window and delimiter compare in parallel.
// Reset is synchronous and needs no clearing pass. Stalls on the output hold
// the results and back-pressure the input through the input register.
module delimiter_string_splitter_unit #(
  parameter int MAX_DELIM_LEN = dss_pkg::MAX_DELIM_LEN
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // data_byte
  input  logic                       in_tuser,   // has_byte
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // out_byte
  output logic [1:0]                 out_tuser,  // {string_done, kind}
  output logic                       out_tlast,
  input  logic                       cfg_we,
  input  logic [dss_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [dss_pkg::CFG_DW-1:0] cfg_wdata
);
  import dss_pkg::*;

  localparam int BW = $clog2(MAX_DELIM_LEN + 2);

  cfg_t                   cfg;
  logic                   emit_free;
  logic                   bnd_load;
  res_t [MAX_DELIM_LEN:0] bnd_ent;
  logic [BW-1:0]          bnd_cnt;

  dss_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dss_core #(.P(MAX_DELIM_LEN)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cfg       (cfg),
    .emit_free (emit_free),
    .bnd_load  (bnd_load),
    .bnd_ent   (bnd_ent),
    .bnd_cnt   (bnd_cnt)
  );

  dss_emit #(.P(MAX_DELIM_LEN)) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .bnd_load   (bnd_load),
    .bnd_ent    (bnd_ent),
    .bnd_cnt    (bnd_cnt),
    .emit_free  (emit_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hw/rtl/dss_checker.sv =====
// Port-level checks of the delimiter string splitter, bound to the top level.
module dss_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);
  import dss_pkg::*;

  // No result is offered straight after reset.
  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // Only a token end may close a string.
  a_done_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0] == KIND_END)
    else $error("string end flagged on a token byte");

  // The closing token end is always the final transaction of its item.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("string end not on the last transaction of the item");

  a_end_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] == KIND_END |-> out_tdata == 8'h00)
    else $error("token end carries a nonzero byte");

endmodule

bind delimiter_string_splitter_unit dss_checker u_dss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
